### rtl/lmi_pkg.sv
// Shared widths, action codes and types for the straight-line path stepper.
// No dependencies.
package lmi_pkg;

    localparam int COORD_W = 16;
    localparam int STEP_W  = 17;
    localparam int LEN_W   = 8;
    localparam int PROD_W  = COORD_W + STEP_W;
    localparam int RAD_W   = PROD_W + 1;
    localparam int SREM_W  = STEP_W + 1;
    localparam int CNT_W   = 5;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(STEP_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(RAD_W / 2 - 1);
    localparam logic [CNT_W-1:0] LDIV_LAST = CNT_W'(STEP_W - 1);
    localparam logic [CNT_W-1:0] ADIV_LAST = CNT_W'(COORD_W - 1);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [COORD_W-1:0] t_mag;
    typedef logic        [STEP_W-1:0]  t_step;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_START,
        OP_ADVANCE
    } t_op;

endpackage

### rtl/linear_move_interpolator_top.sv
// Straight-line path stepper with bit-serial multiply, root and divide; uses lmi_pkg.
// Sequence from accepting edge to result: start runs multiply, root, divide and finish,
// advance runs multiply, divide and finish, and words that do no arithmetic go straight to finish.
// One word in flight, the next taken the cycle after finish; a result held in the output
// register stalls finish.
// Synchronous active-low reset: idle, step length 16, step index 1, limit 0.
module linear_move_interpolator_top import lmi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  t_coord             i_from_x,
    input  t_coord             i_from_y,
    input  t_coord             i_target_x,
    input  t_coord             i_target_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LEN_W-1:0]   i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_step              o_step_total,
    output logic               o_point_valid,
    output t_coord             o_point_x,
    output t_coord             o_point_y,
    output logic               o_running
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_LDIV = 3'd3;
    localparam logic [2:0] S_ADIV = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    t_op               r_op;
    logic [LEN_W-1:0]  r_step_len;

    t_coord            r_origin [2];
    t_mag              r_mag    [2];
    logic              r_neg    [2];
    t_step             r_index;
    t_step             r_limit;

    // multiplier lanes: high half accumulates, low half holds multiplier then product
    t_mag              r_phi    [2];
    t_step             r_plo    [2];
    // advance divider lanes
    t_step             r_arem   [2];
    t_mag              r_aq     [2];
    // root and length divider
    logic [RAD_W-1:0]  r_rad;
    logic [SREM_W-1:0] r_srem;
    t_step             r_root;
    logic [LEN_W-1:0]  r_lrem;

    logic              r_out_valid;
    t_step             r_out_total;
    logic              r_out_pvalid;
    t_coord            r_out_x;
    t_coord            r_out_y;
    logic              r_out_running;

    logic              accept;
    logic              slot_free;
    logic              cnt_done;
    logic [COORD_W:0]  dspan    [2];
    t_mag              dmag     [2];
    logic              span_zero;
    logic [COORD_W:0]  mul_sum  [2];
    logic [STEP_W:0]   adiv_t   [2];
    logic              adiv_ge  [2];
    logic [STEP_W:0]   adiv_sub [2];
    logic [SREM_W+1:0] sqrt_t;
    logic [SREM_W+1:0] sqrt_trial;
    logic              sqrt_ge;
    logic [SREM_W+1:0] sqrt_sub;
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W:0]    ldiv_t;
    logic              ldiv_ge;
    logic [LEN_W:0]    ldiv_sub;
    t_step             n_index;
    logic [PROD_W-1:0] prod     [2];
    t_coord            pt       [2];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign cnt_done    = (r_cnt == '0);
    assign len_eff     = (r_step_len == '0) ? LEN_W'(1) : r_step_len;
    assign n_index     = r_index + STEP_W'(1);

    always_comb begin
        dspan[0] = {i_target_x[COORD_W-1], i_target_x} - {i_from_x[COORD_W-1], i_from_x};
        dspan[1] = {i_target_y[COORD_W-1], i_target_y} - {i_from_y[COORD_W-1], i_from_y};
        for (int l = 0; l < 2; l++) begin
            dmag[l]     = dspan[l][STEP_W-1] ? COORD_W'(-dspan[l]) : dspan[l][COORD_W-1:0];
            mul_sum[l]  = {1'b0, r_phi[l]} + (r_plo[l][0] ? {1'b0, r_mag[l]} : '0);
            adiv_t[l]   = {r_arem[l], r_aq[l][COORD_W-1]};
            adiv_ge[l]  = (adiv_t[l] >= {1'b0, r_limit});
            adiv_sub[l] = adiv_t[l] - {1'b0, r_limit};
            prod[l]     = {mul_sum[l], r_plo[l][STEP_W-1:1]};
            pt[l]       = r_neg[l] ? r_origin[l] - t_coord'(r_aq[l])
                                   : r_origin[l] + t_coord'(r_aq[l]);
        end
        span_zero  = (dmag[0] == '0) && (dmag[1] == '0);
        sqrt_t     = {r_srem, r_rad[RAD_W-1 -: 2]};
        sqrt_trial = {1'b0, r_root, 2'b01};
        sqrt_ge    = (sqrt_t >= sqrt_trial);
        sqrt_sub   = sqrt_t - sqrt_trial;
        ldiv_t     = {r_lrem, r_root[STEP_W-1]};
        ldiv_ge    = (ldiv_t >= {1'b0, len_eff});
        ldiv_sub   = ldiv_t - {1'b0, len_eff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_op        <= OP_NONE;
            r_step_len  <= LEN_RESET;
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_mag[0]    <= '0;
            r_mag[1]    <= '0;
            r_neg[0]    <= 1'b0;
            r_neg[1]    <= 1'b0;
            r_index     <= STEP_W'(1);
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step_len <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= OP_NONE;
                        r_state <= S_FIN;
                        case (i_action)
                            ACT_START: begin
                                r_op        <= OP_START;
                                r_origin[0] <= i_from_x;
                                r_origin[1] <= i_from_y;
                                for (int l = 0; l < 2; l++) begin
                                    r_mag[l] <= dmag[l];
                                    r_neg[l] <= dspan[l][STEP_W-1];
                                    r_phi[l] <= '0;
                                    r_plo[l] <= STEP_W'(dmag[l]);
                                end
                                if (span_zero) begin
                                    r_index <= STEP_W'(1);
                                    r_limit <= '0;
                                end else begin
                                    r_index <= '0;
                                    r_cnt   <= MUL_LAST;
                                    r_state <= S_MUL;
                                end
                            end
                            ACT_ADVANCE: begin
                                if (r_index < r_limit) begin
                                    r_op    <= OP_ADVANCE;
                                    r_index <= n_index;
                                    for (int l = 0; l < 2; l++) begin
                                        r_phi[l] <= '0;
                                        r_plo[l] <= n_index;
                                    end
                                    r_cnt   <= MUL_LAST;
                                    r_state <= S_MUL;
                                end
                            end
                            ACT_STOP: begin
                                r_index <= STEP_W'(1);
                                r_limit <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    for (int l = 0; l < 2; l++) begin
                        r_phi[l] <= mul_sum[l][COORD_W:1];
                        r_plo[l] <= {mul_sum[l][0], r_plo[l][STEP_W-1:1]};
                    end
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (cnt_done) begin
                        if (r_op == OP_START) begin
                            r_rad   <= {1'b0, prod[0]} + {1'b0, prod[1]};
                            r_srem  <= '0;
                            r_root  <= '0;
                            r_cnt   <= SQRT_LAST;
                            r_state <= S_SQRT;
                        end else begin
                            for (int l = 0; l < 2; l++) begin
                                r_arem[l] <= prod[l][PROD_W-1 -: STEP_W];
                                r_aq[l]   <= prod[l][COORD_W-1:0];
                            end
                            r_cnt   <= ADIV_LAST;
                            r_state <= S_ADIV;
                        end
                    end
                end
                S_SQRT: begin
                    r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                    r_srem <= sqrt_ge ? sqrt_sub[SREM_W-1:0] : sqrt_t[SREM_W-1:0];
                    r_root <= {r_root[STEP_W-2:0], sqrt_ge};
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (cnt_done) begin
                        r_lrem  <= '0;
                        r_cnt   <= LDIV_LAST;
                        r_state <= S_LDIV;
                    end
                end
                S_LDIV: begin
                    r_lrem <= ldiv_ge ? ldiv_sub[LEN_W-1:0] : ldiv_t[LEN_W-1:0];
                    r_root <= {r_root[STEP_W-2:0], ldiv_ge};
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (cnt_done) begin
                        r_limit <= {r_root[STEP_W-2:0], ldiv_ge} + STEP_W'(1);
                        r_state <= S_FIN;
                    end
                end
                S_ADIV: begin
                    for (int l = 0; l < 2; l++) begin
                        r_arem[l] <= adiv_ge[l] ? adiv_sub[l][STEP_W-1:0]
                                                : adiv_t[l][STEP_W-1:0];
                        r_aq[l]   <= {r_aq[l][COORD_W-2:0], adiv_ge[l]};
                    end
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (cnt_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && slot_free) begin
            r_out_total   <= (r_op == OP_START) ? r_limit : '0;
            r_out_pvalid  <= (r_op == OP_ADVANCE);
            r_out_x       <= (r_op == OP_ADVANCE) ? pt[0] : '0;
            r_out_y       <= (r_op == OP_ADVANCE) ? pt[1] : '0;
            r_out_running <= (r_index < r_limit);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_total  = r_out_total;
    assign o_point_valid = r_out_pvalid;
    assign o_point_x     = r_out_x;
    assign o_point_y     = r_out_y;
    assign o_running     = r_out_running;

endmodule
